### sv/sdb_pkg.sv
// Shared types and constants for the stopping distance bound block.
`default_nettype none

package sdb_pkg;

    localparam int CFG_W   = 32;
    localparam int SPEED_W = 32;
    localparam int OUT_W   = 48;
    localparam int PROD_W  = 2 * SPEED_W;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_MAX_SPEED     = 2'd0;
    localparam logic [IDX_W-1:0] REG_ACCEL_RATE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_REACTION_TIME = 2'd2;
    localparam logic [IDX_W-1:0] REG_BRAKE_RATE    = 2'd3;

    // Motion during the reaction time
    localparam logic [1:0] BR_HOLD  = 2'd0;
    localparam logic [1:0] BR_ACCEL = 2'd1;
    localparam logic [1:0] BR_DECEL = 2'd2;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      speed_known;
    } t_sdb_in;

    typedef struct packed {
        logic [OUT_W-1:0] stop_travel;
        logic             saturated;
    } t_sdb_out;

endpackage

`default_nettype wire

### sv/sdb_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none

module sdb_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_den,
    output logic [SW-1:0]      o_side
);

    logic          r_vld  [1:NW];
    logic [DW-1:0] r_rem  [1:NW];
    logic [NW-1:0] r_nq   [1:NW];
    logic [DW-1:0] r_den  [1:NW];
    logic [SW-1:0] r_side [1:NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          src_vld;
        logic [DW-1:0] src_rem;
        logic [NW-1:0] src_nq;
        logic [DW-1:0] src_den;
        logic [SW-1:0] src_side;
        logic [DW:0]   trial;
        logic          fits;

        if (k == 0) begin : g_first
            assign src_vld  = i_valid;
            assign src_rem  = '0;
            assign src_nq   = i_num;
            assign src_den  = i_den;
            assign src_side = i_side;
        end else begin : g_next
            assign src_vld  = r_vld[k];
            assign src_rem  = r_rem[k];
            assign src_nq   = r_nq[k];
            assign src_den  = r_den[k];
            assign src_side = r_side[k];
        end

        // shift in the next numerator bit, subtract when the divisor fits
        assign trial = {src_rem, src_nq[NW-1]};
        assign fits  = trial >= {1'b0, src_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= fits ? DW'(trial - {1'b0, src_den}) : DW'(trial);
                r_nq[k+1]   <= {src_nq[NW-2:0], fits};
                r_den[k+1]  <= src_den;
                r_side[k+1] <= src_side;
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo   = r_nq[NW];
    assign o_den   = r_den[NW];
    assign o_side  = r_side[NW];

endmodule

`default_nettype wire

### sv/stopping_distance_bound_top.sv
// Top level of the worst-case stopping distance bound pipeline.
`default_nettype none

// Gives, for each speed transaction, an upper bound on the travel before
// standstill in unsigned fixed point with FRAC_BITS fraction bits (48-bit
// result, saturated with a flag). A new transaction is taken every cycle
// while the pipeline advances; each one passes two bit-per-stage dividers
// (reaction-limited ramp time and braking distance v*v/(2*brake_rate)).
// The whole pipeline advances together and holds while the output register
// is full and not taken, so ready follows the output side. Configuration
// is a plain write port and must only be written while no transaction is
// in flight; a braking rate of zero acts as one least significant bit.

module stopping_distance_bound_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire sdb_pkg::t_sdb_in              i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output sdb_pkg::t_sdb_out                  o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [sdb_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sdb_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int SW     = sdb_pkg::SPEED_W;
    localparam int PW     = sdb_pkg::PROD_W;
    localparam int NUM1_W = SW + FRAC_BITS;
    localparam int R_W    = PW - FRAC_BITS + 1;
    localparam int TOT_W  = PW + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SW-1:0] r_max_speed, r_accel_rate, r_reaction_time, r_brake_rate;
    logic [SW-1:0] brake_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed     <= '0;
            r_accel_rate    <= '0;
            r_reaction_time <= '0;
            r_brake_rate    <= SW'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdb_pkg::REG_MAX_SPEED:     r_max_speed     <= i_cfg_data;
                sdb_pkg::REG_ACCEL_RATE:    r_accel_rate    <= i_cfg_data;
                sdb_pkg::REG_REACTION_TIME: r_reaction_time <= i_cfg_data;
                sdb_pkg::REG_BRAKE_RATE:    r_brake_rate    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a zero braking rate counts as one LSB
    assign brake_eff = (r_brake_rate == '0) ? SW'(1) : r_brake_rate;

    // ---------------------------------------------------------------
    // Global advance: move every stage when the output slot is free
    // ---------------------------------------------------------------
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // ---------------------------------------------------------------
    // Stage 1: magnitude, limit substitution, branch choice
    // ---------------------------------------------------------------
    logic [SW-1:0]     raw, mag, s_eff, diff;
    logic              go_accel, go_decel;
    logic [1:0]        n_s1_br;

    assign raw      = i_in_data.speed;
    assign mag      = raw[SW-1] ? (~raw + SW'(1)) : raw;
    assign s_eff    = i_in_data.speed_known ? mag : r_max_speed;
    assign go_accel = (s_eff < r_max_speed) && (r_accel_rate != '0);
    assign go_decel = s_eff > r_max_speed;
    assign diff     = go_accel ? (r_max_speed - s_eff) : (s_eff - r_max_speed);
    assign n_s1_br  = go_accel ? sdb_pkg::BR_ACCEL :
                      go_decel ? sdb_pkg::BR_DECEL : sdb_pkg::BR_HOLD;

    logic              r_s1_vld;
    logic [SW-1:0]     r_s1_s, r_s1_den;
    logic [NUM1_W-1:0] r_s1_num;
    logic [1:0]        r_s1_br;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_s   <= s_eff;
            r_s1_br  <= n_s1_br;
            r_s1_num <= {diff, FRAC_BITS'(0)};
            r_s1_den <= go_accel ? r_accel_rate : brake_eff;
        end
    end

    // ---------------------------------------------------------------
    // Ramp time: (|s - M| << F) / rate
    // ---------------------------------------------------------------
    logic              d1_vld;
    logic [NUM1_W-1:0] d1_quo;
    logic [SW-1:0]     d1_den;
    logic [SW+1:0]     d1_side;

    sdb_div #(.NW(NUM1_W), .DW(SW), .SW(SW + 2)) u_ramp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_vld),
        .i_num   (r_s1_num),
        .i_den   (r_s1_den),
        .i_side  ({r_s1_br, r_s1_s}),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_den   (d1_den),
        .o_side  (d1_side)
    );

    // ---------------------------------------------------------------
    // Stage 2: clip ramp time to the reaction time (zero when holding)
    // ---------------------------------------------------------------
    logic              r_s2_vld;
    logic [SW-1:0]     r_s2_s, r_s2_den, r_s2_t;
    logic [1:0]        r_s2_br;
    logic [SW-1:0]     n_s2_t;

    always_comb begin
        if (d1_side[SW+1:SW] == sdb_pkg::BR_HOLD) begin
            n_s2_t = '0;
        end else if (d1_quo < NUM1_W'(r_reaction_time)) begin
            n_s2_t = d1_quo[SW-1:0];
        end else begin
            n_s2_t = r_reaction_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_s   <= d1_side[SW-1:0];
            r_s2_br  <= d1_side[SW+1:SW];
            r_s2_den <= d1_den;
            r_s2_t   <= n_s2_t;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: rate * t
    // ---------------------------------------------------------------
    logic          r_s3_vld;
    logic [SW-1:0] r_s3_s, r_s3_t;
    logic [1:0]    r_s3_br;
    logic [PW-1:0] r_s3_rt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_s  <= r_s2_s;
            r_s3_t  <= r_s2_t;
            r_s3_br <= r_s2_br;
            r_s3_rt <= PW'(r_s2_den) * PW'(r_s2_t);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: speed change and speed at end of reaction
    // ---------------------------------------------------------------
    // dv never exceeds |s - M|, so it and v fit the speed width
    logic [SW-1:0] dv;
    assign dv = SW'(r_s3_rt >> FRAC_BITS);

    logic          r_s4_vld;
    logic [SW-1:0] r_s4_s, r_s4_t, r_s4_dv, r_s4_v, r_s4_trem;
    logic [1:0]    r_s4_br;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_s    <= r_s3_s;
            r_s4_t    <= r_s3_t;
            r_s4_dv   <= dv;
            r_s4_v    <= (r_s3_br == sdb_pkg::BR_DECEL) ? (r_s3_s - dv) : (r_s3_s + dv);
            r_s4_trem <= r_reaction_time - r_s3_t;
            r_s4_br   <= r_s3_br;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: the four independent products
    // ---------------------------------------------------------------
    logic          r_s5_vld;
    logic [1:0]    r_s5_br;
    logic [PW-1:0] r_s5_st, r_s5_dvt, r_s5_vtr, r_s5_vv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_br  <= r_s4_br;
            r_s5_st  <= PW'(r_s4_s) * PW'(r_s4_t);
            r_s5_dvt <= PW'(r_s4_dv) * PW'(r_s4_t);
            r_s5_vtr <= PW'(r_s4_v) * PW'(r_s4_trem);
            r_s5_vv  <= PW'(r_s4_v) * PW'(r_s4_v);
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: reaction travel (ramp part plus constant part)
    // ---------------------------------------------------------------
    logic [PW-1:0] ramp;
    assign ramp = (r_s5_br == sdb_pkg::BR_DECEL) ? (r_s5_st - (r_s5_dvt >> 1))
                                                 : (r_s5_st + (r_s5_dvt >> 1));

    logic           r_s6_vld;
    logic [R_W-1:0] r_s6_r;
    logic [PW-1:0]  r_s6_vv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (en) begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_r  <= R_W'(ramp >> FRAC_BITS) + R_W'(r_s5_vtr >> FRAC_BITS);
            r_s6_vv <= r_s5_vv;
        end
    end

    // ---------------------------------------------------------------
    // Braking distance: v*v / (2*B)
    // ---------------------------------------------------------------
    logic           d2_vld;
    logic [PW-1:0]  d2_quo;
    logic [SW:0]    d2_den;
    logic [R_W-1:0] d2_side;

    sdb_div #(.NW(PW), .DW(SW + 1), .SW(R_W)) u_brake_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_vld),
        .i_num   (r_s6_vv),
        .i_den   ({brake_eff, 1'b0}),
        .i_side  (r_s6_r),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_den   (d2_den),
        .o_side  (d2_side)
    );

    // ---------------------------------------------------------------
    // Output register: sum and saturate
    // ---------------------------------------------------------------
    logic [TOT_W-1:0] total;
    logic             sat;
    logic             den_unused;

    assign total      = TOT_W'(d2_quo) + TOT_W'(d2_side);
    assign sat        = total > TOT_W'(sdb_pkg::OUT_MAX);
    assign den_unused = ^d2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_data.stop_travel <= sat ? sdb_pkg::OUT_MAX
                                          : total[sdb_pkg::OUT_W-1:0];
            o_out_data.saturated   <= sat | (den_unused & 1'b0);
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |-> o_out_data.stop_travel == sdb_pkg::OUT_MAX)
        else $error("saturated result not clamped");

    a_accel_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld && r_s4_br == sdb_pkg::BR_ACCEL |-> r_s4_v <= r_max_speed)
        else $error("acceleration overshot the limit");

    a_decel_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld && r_s4_br == sdb_pkg::BR_DECEL |-> r_s4_v >= r_max_speed)
        else $error("ramp down undershot the limit");

    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && r_s2_br == sdb_pkg::BR_HOLD |-> r_s2_t == '0)
        else $error("holding transaction has a ramp time");

endmodule

`default_nettype wire
